### hdl/dtq_pkg.sv
// shared types and constants of the deadline timer queue
// used by the top module deadline_timer_queue_unit, depends on nothing
package dtq_pkg;

    localparam int ID_BITS     = 8;
    localparam int PORT_TIME_BITS = 48;
    localparam int WIDE_BITS   = 64;
    localparam int MAX_EXPIRE  = 16;
    localparam int EXPIRE_BITS = $clog2(MAX_EXPIRE + 1);

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    typedef struct packed {
        logic                       operation;
        logic [ID_BITS-1:0]         task_id;
        logic [PORT_TIME_BITS-1:0]  deadline_us;
        logic [PORT_TIME_BITS-1:0]  now_us;
    } item_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [ID_BITS-1:0]         expired_id;
        logic                       rearm;
        logic [PORT_TIME_BITS-1:0]  timeout_us;
        logic                       full_error;
        logic                       last;
    } result_t;

endpackage

### hdl/dtq_mem.sv
// entry store: one write port, one read port with registered read data
// no dependencies
module dtq_mem #(
    parameter int DEPTH = 16,
    parameter int DATA_BITS = 56
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [DATA_BITS-1:0]       wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [DATA_BITS-1:0]       rdata
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/dtq_sub.sv
// shared subtract and compare unit: a - b and a <= b (unsigned)
// no dependencies
module dtq_sub #(
    parameter int WIDTH = 48
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             le
);

    logic [WIDTH:0] full;

    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[WIDTH-1:0];
    // borrow means a < b, zero difference means equal
    assign le   = full[WIDTH] | (full[WIDTH-1:0] == '0);

endmodule

### hdl/deadline_timer_queue_unit.sv
// deadline timer queue: circular sorted store stepped by one sequencer and one subtractor
// add: every queued task with a later deadline moves up one slot, then one result gives the
// head's timeout (re-arm when the new task is the head and not yet due); full queue: full_error
// tick: reports and pops each expired head (at most MAX_EXPIRE) as results are taken, then
// a closing one with the head's timeout; one request at a time, the next once its last result is taken
// reset (async, rst_n low) empties the queue at once; entries stay undefined until written
module deadline_timer_queue_unit
    import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS = 48
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = ID_BITS + TIME_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CMP,
        S_HEAD_RD,
        S_HEAD_CMP,
        S_TICK_RD,
        S_TICK_CMP,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          count_reg;
    logic [IW-1:0]          head_reg;
    logic [IW-1:0]          k_reg;
    logic [EXPIRE_BITS-1:0] n_reg;
    logic                   pos0_reg;
    logic                   cont_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic [TIME_BITS-1:0]   dl_reg;
    logic [TIME_BITS-1:0]   now_reg;
    result_t                result_reg;
    logic                   result_valid_reg;

    logic [WIDE_BITS-1:0]   dl_wide;
    logic [WIDE_BITS-1:0]   now_wide;
    logic [WIDE_BITS-1:0]   diff_wide;

    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [DW-1:0]          mem_wdata;
    logic [IW-1:0]          mem_raddr;
    logic [DW-1:0]          mem_rdata;

    logic [TIME_BITS-1:0]   sub_b;
    logic [TIME_BITS-1:0]   sub_diff;
    logic                   sub_le;
    logic [PORT_TIME_BITS-1:0] timeout;

    // logical slot to physical address, head + slot wrapped once
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [IW-1:0] slot);
        logic [IW:0] sum;
        sum = {1'b0, head} + {1'b0, slot};
        if (sum >= (IW+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (IW+1)'(QUEUE_DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign dl_wide  = WIDE_BITS'(item.deadline_us);
    assign now_wide = WIDE_BITS'(item.now_us);

    dtq_mem #(
        .DEPTH     (QUEUE_DEPTH),
        .DATA_BITS (DW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign sub_b = (state_reg == S_ADD_CMP) ? dl_reg : now_reg;

    dtq_sub #(
        .WIDTH (TIME_BITS)
    ) u_sub (
        .a    (mem_rdata[TIME_BITS-1:0]),
        .b    (sub_b),
        .diff (sub_diff),
        .le   (sub_le)
    );

    assign diff_wide = WIDE_BITS'(sub_diff);
    // head at or before now gives zero
    assign timeout   = sub_le ? '0 : diff_wide[PORT_TIME_BITS-1:0];

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = phys(head_reg, k_reg);
        mem_wdata = {id_reg, dl_reg};
        mem_raddr = head_reg;
        unique case (state_reg)
            S_ADD_RD:
            begin
                mem_raddr = phys(head_reg, k_reg - IW'(1));
                mem_we    = (k_reg == '0);
            end
            S_ADD_CMP:
            begin
                mem_we = 1'b1;
                // later entry moves up one slot, otherwise the new task lands here
                if (!sub_le)
                begin
                    mem_wdata = mem_rdata;
                end
            end
            default:
            begin
                mem_raddr = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            head_reg         <= '0;
            k_reg            <= '0;
            n_reg            <= '0;
            pos0_reg         <= 1'b0;
            cont_reg         <= 1'b0;
            id_reg           <= '0;
            dl_reg           <= '0;
            now_reg          <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        id_reg  <= item.task_id;
                        dl_reg  <= dl_wide[TIME_BITS-1:0];
                        now_reg <= now_wide[TIME_BITS-1:0];
                        n_reg   <= '0;
                        if (item.operation == OP_TICK)
                        begin
                            state_reg <= S_TICK_RD;
                        end
                        else if (count_reg == CW'(QUEUE_DEPTH))
                        begin
                            result_reg       <= '{kind: KIND_ADD, expired_id: '0, rearm: 1'b0,
                                                  timeout_us: '0, full_error: 1'b1,
                                                  last: 1'b1};
                            result_valid_reg <= 1'b1;
                            cont_reg         <= 1'b0;
                            state_reg        <= S_EMIT;
                        end
                        else
                        begin
                            k_reg     <= count_reg[IW-1:0];
                            state_reg <= S_ADD_RD;
                        end
                    end
                end
                S_ADD_RD:
                begin
                    if (k_reg == '0)
                    begin
                        pos0_reg  <= 1'b1;
                        count_reg <= count_reg + CW'(1);
                        state_reg <= S_HEAD_RD;
                    end
                    else
                    begin
                        state_reg <= S_ADD_CMP;
                    end
                end
                S_ADD_CMP:
                begin
                    if (sub_le)
                    begin
                        pos0_reg  <= 1'b0;
                        count_reg <= count_reg + CW'(1);
                        state_reg <= S_HEAD_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg - IW'(1);
                        state_reg <= S_ADD_RD;
                    end
                end
                S_HEAD_RD:
                begin
                    state_reg <= S_HEAD_CMP;
                end
                S_HEAD_CMP:
                begin
                    result_reg       <= '{kind: KIND_ADD, expired_id: '0,
                                          rearm: pos0_reg & ~sub_le, timeout_us: timeout,
                                          full_error: 1'b0, last: 1'b1};
                    result_valid_reg <= 1'b1;
                    cont_reg         <= 1'b0;
                    state_reg        <= S_EMIT;
                end
                S_TICK_RD:
                begin
                    if (count_reg == '0)
                    begin
                        result_reg       <= '{kind: KIND_DONE, expired_id: '0, rearm: 1'b0,
                                              timeout_us: '0, full_error: 1'b0, last: 1'b1};
                        result_valid_reg <= 1'b1;
                        cont_reg         <= 1'b0;
                        state_reg        <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_TICK_CMP;
                    end
                end
                S_TICK_CMP:
                begin
                    if (sub_le && (n_reg < EXPIRE_BITS'(MAX_EXPIRE)))
                    begin
                        // head has expired: report it and pop
                        result_reg       <= '{kind: KIND_EXPIRED,
                                              expired_id: mem_rdata[DW-1:TIME_BITS],
                                              rearm: 1'b0, timeout_us: '0,
                                              full_error: 1'b0, last: 1'b0};
                        head_reg         <= phys(head_reg, IW'(1));
                        count_reg        <= count_reg - CW'(1);
                        n_reg            <= n_reg + EXPIRE_BITS'(1);
                        cont_reg         <= 1'b1;
                    end
                    else
                    begin
                        result_reg       <= '{kind: KIND_DONE, expired_id: '0, rearm: 1'b1,
                                              timeout_us: timeout, full_error: 1'b0,
                                              last: 1'b1};
                        cont_reg         <= 1'b0;
                    end
                    result_valid_reg <= 1'b1;
                    state_reg        <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (result_ready)
                    begin
                        result_valid_reg <= 1'b0;
                        state_reg        <= cont_reg ? S_TICK_RD : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("request taken while a result is pending");

    a_full_add: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.full_error |-> result.kind == KIND_ADD && result.last)
        else $error("full flag on a result that is not a closing add answer");

    a_expired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_EXPIRED |-> !result.last && !result.rearm)
        else $error("expired task result marked last or re-arm");

    a_pop_on_expire: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TICK_CMP && sub_le && n_reg < EXPIRE_BITS'(MAX_EXPIRE)
        |=> count_reg == $past(count_reg) - CW'(1))
        else $error("expired task not popped");
`endif

endmodule
